// File: rtl/rrts_pkg.sv
// ----------------------------------------------------------------------------
// rrts_pkg
// shared types and constants of the round-robin task selector
// ----------------------------------------------------------------------------
package rrts_pkg;

  localparam int NUM_TASKS  = 16;
  localparam int IDX_W      = (NUM_TASKS > 1) ? $clog2(NUM_TASKS) : 1;
  localparam int ID_W       = 16;
  localparam int ST_W       = 2;
  localparam int CTR_W      = ID_W + 1;
  localparam int IN_DATA_W  = 24;
  localparam int OUT_DATA_W = 24;

  typedef logic [IDX_W-1:0] idx_t;
  typedef logic [ID_W-1:0]  tid_t;
  typedef logic [ST_W-1:0]  tst_t;

  typedef enum logic [1:0] {
    KIND_CREATE    = 2'd0,
    KIND_SET_STATE = 2'd1,
    KIND_REMOVE    = 2'd2,
    KIND_SCHEDULE  = 2'd3
  } kind_e;

  localparam tst_t STATE_READY = 2'd0;
  localparam tst_t TASK_ZOMBIE = 2'd2;

  // table write port
  typedef struct packed {
    logic we_entry;   // claim slot: used, id and state
    logic we_state;
    logic clr_used;
    idx_t idx;
    tid_t id;
    tst_t state;
  } tbl_wr_t;

  // table read port
  typedef struct packed {
    logic used;
    tid_t id;
    tst_t state;
  } tbl_rd_t;

  // compare unit flags
  typedef struct packed {
    logic eq_key;
    logic is_zero;
    logic is_ready;
    logic lt_lo;
    logic lt_hi;
    logic gt_run;
  } cmp_t;

endpackage

// File: rtl/rrts_table.sv
// ----------------------------------------------------------------------------
// rrts_table
// task table: used bits in flops, id and state per slot, one read port
// ----------------------------------------------------------------------------
module rrts_table (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  rrts_pkg::tbl_wr_t wr_i,
  input  rrts_pkg::idx_t    rd_idx_i,
  output rrts_pkg::tbl_rd_t rd_o
);
  import rrts_pkg::*;

  logic [NUM_TASKS-1:0] used_q;
  tid_t                 id_q    [NUM_TASKS];
  tst_t                 state_q [NUM_TASKS];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      used_q <= '0;
    end else begin
      if (wr_i.we_entry) begin
        used_q[wr_i.idx] <= 1'b1;
      end else if (wr_i.clr_used) begin
        used_q[wr_i.idx] <= 1'b0;
      end
    end
  end

  // id and state are only read while the slot is used
  always_ff @(posedge clk_i) begin
    if (wr_i.we_entry) begin
      id_q[wr_i.idx]    <= wr_i.id;
      state_q[wr_i.idx] <= wr_i.state;
    end else if (wr_i.we_state) begin
      state_q[wr_i.idx] <= wr_i.state;
    end
  end

  assign rd_o.used  = used_q[rd_idx_i];
  assign rd_o.id    = id_q[rd_idx_i];
  assign rd_o.state = state_q[rd_idx_i];

endmodule

// File: rtl/rrts_cmp.sv
// ----------------------------------------------------------------------------
// rrts_cmp
// shared compare unit, applied to one table entry per cycle
// ----------------------------------------------------------------------------
module rrts_cmp (
  input  rrts_pkg::tbl_rd_t entry_i,
  input  rrts_pkg::tid_t    key_i,
  input  rrts_pkg::tid_t    lo_id_i,
  input  rrts_pkg::tid_t    hi_id_i,
  input  rrts_pkg::tid_t    run_id_i,
  output rrts_pkg::cmp_t    cmp_o
);
  import rrts_pkg::*;

  assign cmp_o.eq_key   = (entry_i.id == key_i);
  assign cmp_o.is_zero  = (entry_i.id == '0);
  assign cmp_o.is_ready = (entry_i.state == STATE_READY);
  assign cmp_o.lt_lo    = (entry_i.id < lo_id_i);
  assign cmp_o.lt_hi    = (entry_i.id < hi_id_i);
  assign cmp_o.gt_run   = (entry_i.id > run_id_i);

endmodule

// File: rtl/round_robin_task_selector_core.sv
// ----------------------------------------------------------------------------
// round_robin_task_selector_core
// task table with create, set state, remove and round-robin schedule
// ----------------------------------------------------------------------------
// channel  dir  handshake                  tdata / tuser
// s_axis   in   s_axis_tvalid_i/tready_o   task_id, new_state / kind
// m_axis   out  m_axis_tvalid_o/tready_i   ok, result_id
//
// every word walks the whole table once through one compare unit:
// create, set state and remove go from idle to the walk and then to done;
// schedule first reads the running slot, then walks and ends in done
// a result waits in the output register; the next word is taken meanwhile,
// but its result is held back until the register is free
// reset empties the table, clears the id counter and the running slot
// ----------------------------------------------------------------------------
module round_robin_task_selector_core (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_axis_tvalid_i,
  output logic                           s_axis_tready_o,
  input  logic [rrts_pkg::IN_DATA_W-1:0] s_axis_tdata_i,   // task_id, new_state
  input  logic [1:0]                     s_axis_tuser_i,   // kind
  output logic                           m_axis_tvalid_o,
  input  logic                           m_axis_tready_i,
  output logic [rrts_pkg::OUT_DATA_W-1:0] m_axis_tdata_o   // ok, result_id
);
  import rrts_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_RUN_RD,
    S_WALK,
    S_DONE
  } state_e;

  state_e state_q, state_d;
  kind_e  kind_q, kind_d;
  tid_t   key_q, key_d;
  tst_t   nst_q, nst_d;
  idx_t   idx_q, idx_d;
  logic   found_q, found_d;
  idx_t   slot_q, slot_d;
  logic   lo_found_q, lo_found_d;
  idx_t   lo_slot_q, lo_slot_d;
  tid_t   lo_id_q, lo_id_d;
  logic   hi_found_q, hi_found_d;
  idx_t   hi_slot_q, hi_slot_d;
  tid_t   hi_id_q, hi_id_d;
  logic   rv_q, rv_d;
  tid_t   rid_q, rid_d;
  logic   rrdy_q, rrdy_d;
  idx_t   run_q, run_d;
  logic [CTR_W-1:0] ctr_q, ctr_d;
  logic   out_valid_q, out_valid_d;
  logic   out_ok_q, out_ok_d;
  tid_t   out_id_q, out_id_d;

  tbl_wr_t wr;
  tbl_rd_t rd;
  idx_t    rd_idx;
  cmp_t    cmp;
  logic    in_acc;
  logic    last_idx;
  logic    cand;
  logic    skip;
  logic    res_ok;
  tid_t    res_id;

  rrts_table u_table (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .wr_i     (wr),
    .rd_idx_i (rd_idx),
    .rd_o     (rd)
  );

  rrts_cmp u_cmp (
    .entry_i  (rd),
    .key_i    (key_q),
    .lo_id_i  (lo_id_q),
    .hi_id_i  (hi_id_q),
    .run_id_i (rid_q),
    .cmp_o    (cmp)
  );

  assign s_axis_tready_o = (state_q == S_IDLE);
  assign in_acc          = s_axis_tvalid_i && s_axis_tready_o;
  assign rd_idx          = (state_q == S_RUN_RD) ? run_q : idx_q;
  assign last_idx        = (idx_q == idx_t'(NUM_TASKS - 1));

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {{(OUT_DATA_W - ID_W - 1){1'b0}}, out_id_q, out_ok_q};

  // the running slot is skipped in the walk only when it holds a task
  assign skip = rv_q && (idx_q == run_q);
  assign cand = rd.used && !skip && !cmp.is_zero && cmp.is_ready;

  // result of the finished walk
  always_comb begin
    res_ok = 1'b0;
    res_id = '0;
    case (kind_q)
      KIND_CREATE: begin
        res_ok = found_q && !ctr_q[CTR_W-1];
        res_id = ctr_q[ID_W-1:0];
      end
      KIND_SET_STATE: begin
        res_ok = found_q && (nst_q <= TASK_ZOMBIE);
      end
      KIND_REMOVE: begin
        res_ok = found_q;
      end
      KIND_SCHEDULE: begin
        if (hi_found_q) begin
          res_ok = 1'b1;
          res_id = hi_id_q;
        end else if (lo_found_q) begin
          res_ok = 1'b1;
          res_id = lo_id_q;
        end else if (rv_q && rrdy_q) begin
          res_ok = 1'b1;
          res_id = rid_q;
        end else if (found_q) begin
          res_ok = 1'b1;
        end
      end
      default: begin
        res_ok = 1'b0;
      end
    endcase
    if (!res_ok) begin
      res_id = '0;
    end
  end

  always_comb begin
    state_d     = state_q;
    kind_d      = kind_q;
    key_d       = key_q;
    nst_d       = nst_q;
    idx_d       = idx_q;
    found_d     = found_q;
    slot_d      = slot_q;
    lo_found_d  = lo_found_q;
    lo_slot_d   = lo_slot_q;
    lo_id_d     = lo_id_q;
    hi_found_d  = hi_found_q;
    hi_slot_d   = hi_slot_q;
    hi_id_d     = hi_id_q;
    rv_d        = rv_q;
    rid_d       = rid_q;
    rrdy_d      = rrdy_q;
    run_d       = run_q;
    ctr_d       = ctr_q;
    out_valid_d = out_valid_q && !m_axis_tready_i;
    out_ok_d    = out_ok_q;
    out_id_d    = out_id_q;
    wr          = '0;
    wr.idx      = slot_q;

    case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          kind_d     = kind_e'(s_axis_tuser_i);
          key_d      = s_axis_tdata_i[ID_W-1:0];
          nst_d      = s_axis_tdata_i[ID_W+ST_W-1:ID_W];
          idx_d      = '0;
          found_d    = 1'b0;
          lo_found_d = 1'b0;
          hi_found_d = 1'b0;
          state_d    = (kind_e'(s_axis_tuser_i) == KIND_SCHEDULE) ? S_RUN_RD : S_WALK;
        end
      end
      S_RUN_RD: begin
        rv_d    = rd.used;
        rid_d   = rd.used ? rd.id : '0;
        rrdy_d  = rd.state == STATE_READY;
        state_d = S_WALK;
      end
      S_WALK: begin
        case (kind_q)
          KIND_CREATE: begin
            if (!found_q && !rd.used) begin
              found_d = 1'b1;
              slot_d  = idx_q;
            end
          end
          KIND_SET_STATE, KIND_REMOVE: begin
            if (!found_q && rd.used && cmp.eq_key) begin
              found_d = 1'b1;
              slot_d  = idx_q;
            end
          end
          KIND_SCHEDULE: begin
            if (cand && (!lo_found_q || cmp.lt_lo)) begin
              lo_found_d = 1'b1;
              lo_slot_d  = idx_q;
              lo_id_d    = rd.id;
            end
            if (cand && (!rv_q || cmp.gt_run) && (!hi_found_q || cmp.lt_hi)) begin
              hi_found_d = 1'b1;
              hi_slot_d  = idx_q;
              hi_id_d    = rd.id;
            end
            // fallback: lowest slot holding id zero, whatever its state
            if (!found_q && rd.used && cmp.is_zero) begin
              found_d = 1'b1;
              slot_d  = idx_q;
            end
          end
          default: begin
            found_d = found_q;
          end
        endcase
        idx_d = idx_q + 1'b1;
        if (last_idx) begin
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        if (!out_valid_q || m_axis_tready_i) begin
          out_valid_d = 1'b1;
          out_ok_d    = res_ok;
          out_id_d    = res_id;
          state_d     = S_IDLE;
          case (kind_q)
            KIND_CREATE: begin
              wr.we_entry = res_ok;
              wr.id       = ctr_q[ID_W-1:0];
              wr.state    = STATE_READY;
              if (res_ok) begin
                ctr_d = ctr_q + 1'b1;
              end
            end
            KIND_SET_STATE: begin
              wr.we_state = res_ok;
              wr.state    = nst_q;
            end
            KIND_REMOVE: begin
              wr.clr_used = res_ok;
            end
            KIND_SCHEDULE: begin
              if (hi_found_q) begin
                run_d = hi_slot_q;
              end else if (lo_found_q) begin
                run_d = lo_slot_q;
              end else if (rv_q && rrdy_q) begin
                run_d = run_q;
              end else if (found_q) begin
                run_d = slot_q;
              end
            end
            default: begin
              wr = '0;
            end
          endcase
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      kind_q      <= KIND_CREATE;
      idx_q       <= '0;
      found_q     <= 1'b0;
      lo_found_q  <= 1'b0;
      hi_found_q  <= 1'b0;
      rv_q        <= 1'b0;
      rrdy_q      <= 1'b0;
      run_q       <= '0;
      ctr_q       <= '0;
      out_valid_q <= 1'b0;
      out_ok_q    <= 1'b0;
      out_id_q    <= '0;
    end else begin
      state_q     <= state_d;
      kind_q      <= kind_d;
      idx_q       <= idx_d;
      found_q     <= found_d;
      lo_found_q  <= lo_found_d;
      hi_found_q  <= hi_found_d;
      rv_q        <= rv_d;
      rrdy_q      <= rrdy_d;
      run_q       <= run_d;
      ctr_q       <= ctr_d;
      out_valid_q <= out_valid_d;
      out_ok_q    <= out_ok_d;
      out_id_q    <= out_id_d;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q     <= key_d;
    nst_q     <= nst_d;
    slot_q    <= slot_d;
    lo_slot_q <= lo_slot_d;
    lo_id_q   <= lo_id_d;
    hi_slot_q <= hi_slot_d;
    hi_id_q   <= hi_id_d;
    rid_q     <= rid_d;
  end

endmodule

// File: rtl/rrts_checker.sv
// ----------------------------------------------------------------------------
// rrts_checker
// port-level checks of the round-robin task selector
// ----------------------------------------------------------------------------
module rrts_checker (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            s_axis_tvalid_i,
  input logic                            s_axis_tready_o,
  input logic                            m_axis_tvalid_o,
  input logic                            m_axis_tready_i,
  input logic [rrts_pkg::OUT_DATA_W-1:0] m_axis_tdata_o
);
  import rrts_pkg::*;

  // stalled output word holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && !m_axis_tready_i) |=>
      (m_axis_tvalid_o && $stable(m_axis_tdata_o)))
    else $error("output word changed while stalled");

  // a refused operation reports id zero
  a_fail_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && !m_axis_tdata_o[0]) |-> (m_axis_tdata_o[ID_W:1] == '0))
    else $error("nonzero id on a failed word");

  // block is busy right after taking a word
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid_i && s_axis_tready_o) |=> !s_axis_tready_o)
    else $error("ready right after accept");

  // a result is loaded only in the done state, so no new result appears at once
  a_no_instant: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid_i && s_axis_tready_o && !m_axis_tvalid_o) |=> !m_axis_tvalid_o)
    else $error("result one cycle after accept");

endmodule

bind round_robin_task_selector_core rrts_checker u_rrts_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .s_axis_tvalid_i (s_axis_tvalid_i),
  .s_axis_tready_o (s_axis_tready_o),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o)
);

// File: tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the round-robin task selector core
// ----------------------------------------------------------------------------
// words go in on s_axis as create, set state, remove and schedule requests.
// a task table model in the bench predicts every reply and the reply stream
// is compared field by field in order. a short table of directed words hits
// the empty table, unknown ids, the bad state code, round-robin wrap, the
// fallback task, removal of the running task and a full table. random
// traffic follows under four idle/stall mixes, with one long sink hold-off
// that backs the block up onto its input.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import rrts_pkg::*;

  localparam tst_t TASK_WAITING = 2'd1;
  localparam tst_t TASK_BADCODE = 2'd3;
  localparam int   WORDS_PER_PHASE = 275;
  localparam int   HOLD_CYCLES     = 300;
  localparam int   MAX_REPORTS     = 10;

  typedef struct packed {
    logic ok;
    tid_t rid;
  } task_reply_t;

  typedef struct {
    kind_e kind;
    tid_t  id;
    tst_t  st;
    int    reps;
    bit    typed;
    bit    ok;
    tid_t  rid;
  } dir_row_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  s_axis_tvalid_i = 1'b0;
  logic                  s_axis_tready_o;
  logic [IN_DATA_W-1:0]  s_axis_tdata_i = '0;
  logic [1:0]            s_axis_tuser_i = '0;
  logic                  m_axis_tvalid_o;
  logic                  m_axis_tready_i = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata_o;

  // task table mirror
  bit         tbl_used [NUM_TASKS];
  tid_t       tbl_id   [NUM_TASKS];
  tst_t       tbl_st   [NUM_TASKS];
  logic [CTR_W-1:0] next_id = '0;
  idx_t       run_slot = '0;

  task_reply_t replies_pending [$];
  int          n_mismatch = 0;
  int          src_idle_pct = 0;
  int          sink_stall_pct = 0;
  int          hold_seq = 0;
  int          hold_seen = 0;
  int          hold_cnt = 0;

  round_robin_task_selector_core i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_axis_tvalid_i),
    .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i (s_axis_tdata_i),   // task_id, new_state
    .s_axis_tuser_i (s_axis_tuser_i),   // kind
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_axis_tready_i),
    .m_axis_tdata_o (m_axis_tdata_o)    // ok, result_id
  );

  always #1 clk_i = ~clk_i;

  function automatic int slot_of(tid_t id);
    for (int i = 0; i < NUM_TASKS; i++) begin
      if (tbl_used[i] && tbl_id[i] == id) return i;
    end
    return -1;
  endfunction

  // ready nonzero id after the running one, wrapping; else it if ready, or id 0
  function automatic int pick_slot();
    int   hi;
    int   lo;
    bit   rv;
    tid_t rid;
    hi = -1;
    lo = -1;
    rv = tbl_used[run_slot];
    rid = rv ? tbl_id[run_slot] : '0;
    for (int i = 0; i < NUM_TASKS; i++) begin
      if (!tbl_used[i] || (rv && i == int'(run_slot))) continue;
      if (tbl_id[i] == '0 || tbl_st[i] != STATE_READY) continue;
      if (lo < 0 || tbl_id[i] < tbl_id[lo]) lo = i;
      if ((!rv || tbl_id[i] > rid) && (hi < 0 || tbl_id[i] < tbl_id[hi])) hi = i;
    end
    if (hi >= 0) return hi;
    if (lo >= 0) return lo;
    if (rv && tbl_st[run_slot] == STATE_READY) return int'(run_slot);
    return slot_of('0);
  endfunction

  function automatic task_reply_t apply_task_op(kind_e k, tid_t id, tst_t st);
    task_reply_t r;
    int          s;
    r = '0;
    case (k)
      KIND_CREATE: begin
        s = -1;
        for (int i = NUM_TASKS - 1; i >= 0; i--) begin
          if (!tbl_used[i]) s = i;
        end
        // ids run out once the counter reaches 2**16
        if (s >= 0 && !next_id[ID_W]) begin
          tbl_used[s] = 1'b1;
          tbl_id[s]   = next_id[ID_W-1:0];
          tbl_st[s]   = STATE_READY;
          r.rid       = next_id[ID_W-1:0];
          r.ok        = 1'b1;
          next_id     = next_id + 1'b1;
        end
      end
      KIND_SET_STATE: begin
        s = slot_of(id);
        if (s >= 0 && st != TASK_BADCODE) begin
          tbl_st[s] = st;
          r.ok = 1'b1;
        end
      end
      KIND_REMOVE: begin
        s = slot_of(id);
        if (s >= 0) begin
          tbl_used[s] = 1'b0;
          r.ok = 1'b1;
        end
      end
      default: begin
        s = pick_slot();
        if (s >= 0) begin
          run_slot = idx_t'(s);
          r.rid = tbl_id[s];
          r.ok = 1'b1;
        end
      end
    endcase
    return r;
  endfunction

  function automatic void flag_mismatch(string what, int exp_v, int act_v);
    n_mismatch++;
    if (n_mismatch <= MAX_REPORTS) begin
      $display("%0t: %s: expected %0d, got %0d", $realtime, what, exp_v, act_v);
    end
  endfunction

  // called in the time step of a rising edge; returns in the step of the
  // edge that accepted the word, with tvalid still high
  task automatic send_word(kind_e k, tid_t id, tst_t st, bit typed = 1'b0,
                           task_reply_t typed_reply = '0);
    task_reply_t r;
    while ($urandom_range(99) < src_idle_pct) begin
      s_axis_tvalid_i <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= {{(IN_DATA_W - ID_W - ST_W){1'b0}}, st, id};
    s_axis_tuser_i  <= k;
    do @(posedge clk_i); while (!s_axis_tready_o);
    r = apply_task_op(k, id, st);
    replies_pending.push_back(typed ? typed_reply : r);
  endtask

  // random word, mostly aimed at live ids so lookups hit
  task automatic send_random_word();
    int   pick;
    int   live [$];
    kind_e k;
    tid_t id;
    tst_t st;
    for (int i = 0; i < NUM_TASKS; i++) begin
      if (tbl_used[i]) live.push_back(i);
    end
    pick = $urandom_range(99);
    id = tid_t'($urandom_range(65535));
    st = tst_t'($urandom_range(3));
    if (pick < 30) begin
      k = KIND_CREATE;
    end else if (pick < 60) begin
      k = KIND_SET_STATE;
      st = ($urandom_range(9) == 0) ? TASK_BADCODE : tst_t'($urandom_range(2));
    end else if (pick < 75) begin
      k = KIND_REMOVE;
    end else begin
      k = KIND_SCHEDULE;
    end
    if ((k == KIND_SET_STATE || k == KIND_REMOVE) && live.size() != 0 &&
        $urandom_range(99) < 85) begin
      id = tbl_id[live[$urandom_range(live.size() - 1)]];
    end
    send_word(k, id, st);
  endtask

  dir_row_t dir_rows [0:24] = '{
    // empty table: nothing to schedule, nothing to find
    '{KIND_SCHEDULE,  16'h0000, STATE_READY,  1, 1, 0, 16'd0},
    '{KIND_SET_STATE, 16'hffff, TASK_BADCODE, 1, 1, 0, 16'd0},
    '{KIND_REMOVE,    16'hffff, STATE_READY,  1, 1, 0, 16'd0},
    '{KIND_CREATE,    16'h0000, STATE_READY,  1, 1, 1, 16'd0},
    '{KIND_CREATE,    16'h0000, STATE_READY,  1, 1, 1, 16'd1},
    '{KIND_CREATE,    16'h0000, STATE_READY,  1, 1, 1, 16'd2},
    '{KIND_SCHEDULE,  16'h0000, STATE_READY,  1, 0, 0, 16'd0},
    '{KIND_SCHEDULE,  16'h0000, STATE_READY,  1, 0, 0, 16'd0},
    // wraps back to the lowest nonzero id
    '{KIND_SCHEDULE,  16'h0000, STATE_READY,  1, 0, 0, 16'd0},
    '{KIND_SET_STATE, 16'd1,    TASK_BADCODE, 1, 1, 0, 16'd0},
    '{KIND_SET_STATE, 16'd1,    TASK_WAITING, 1, 1, 1, 16'd0},
    '{KIND_SCHEDULE,  16'h0000, STATE_READY,  1, 0, 0, 16'd0},
    // only the running task is ready: it stays
    '{KIND_SCHEDULE,  16'h0000, STATE_READY,  1, 0, 0, 16'd0},
    '{KIND_SET_STATE, 16'd2,    TASK_ZOMBIE,  1, 1, 1, 16'd0},
    '{KIND_SCHEDULE,  16'h0000, STATE_READY,  1, 0, 0, 16'd0},
    // id 0 is taken even when it is not ready
    '{KIND_SET_STATE, 16'd0,    TASK_ZOMBIE,  1, 1, 1, 16'd0},
    '{KIND_SCHEDULE,  16'h0000, STATE_READY,  1, 0, 0, 16'd0},
    // removing the running task leaves the running slot empty
    '{KIND_REMOVE,    16'd0,    STATE_READY,  1, 1, 1, 16'd0},
    '{KIND_SET_STATE, 16'd1,    STATE_READY,  1, 1, 1, 16'd0},
    '{KIND_SCHEDULE,  16'h0000, STATE_READY,  1, 0, 0, 16'd0},
    '{KIND_SET_STATE, 16'd1,    TASK_WAITING, 1, 0, 0, 16'd0},
    '{KIND_REMOVE,    16'd2,    STATE_READY,  1, 0, 0, 16'd0},
    // nothing ready and no id 0 left
    '{KIND_SCHEDULE,  16'h0000, STATE_READY,  1, 0, 0, 16'd0},
    '{KIND_CREATE,    16'h0000, STATE_READY, 15, 0, 0, 16'd0},
    // table full
    '{KIND_CREATE,    16'h0000, STATE_READY,  1, 1, 0, 16'd0}
  };

  // sink side: random stalls plus a single long hold-off
  always @(posedge clk_i) begin
    if (hold_cnt > 0) begin
      hold_cnt <= hold_cnt - 1;
      m_axis_tready_i <= 1'b0;
    end else if (hold_seq != hold_seen) begin
      hold_seen <= hold_seq;
      hold_cnt <= HOLD_CYCLES;
      m_axis_tready_i <= 1'b0;
    end else begin
      m_axis_tready_i <= ($urandom_range(99) >= sink_stall_pct);
    end
  end

  always @(posedge clk_i) begin
    task_reply_t exp_r;
    task_reply_t act_r;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      act_r.ok  = m_axis_tdata_o[0];
      act_r.rid = m_axis_tdata_o[ID_W:1];
      if (replies_pending.size() == 0) begin
        flag_mismatch("reply with none pending, rid", -1, int'(act_r.rid));
      end else begin
        exp_r = replies_pending.pop_front();
        if (act_r.ok !== exp_r.ok) flag_mismatch("ok", exp_r.ok, act_r.ok);
        if (act_r.rid !== exp_r.rid) flag_mismatch("result_id", exp_r.rid, act_r.rid);
      end
    end
  end

  initial begin
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_rows[n]) begin
      for (int j = 0; j < dir_rows[n].reps; j++) begin
        send_word(dir_rows[n].kind, dir_rows[n].id, dir_rows[n].st, dir_rows[n].typed,
                  task_reply_t'{ok: dir_rows[n].ok, rid: dir_rows[n].rid});
      end
    end

    // idle mixes: none, source gaps, sink stalls, both
    for (int ph = 0; ph < 4; ph++) begin
      src_idle_pct = (ph == 1) ? 50 : (ph == 3) ? 17 : 0;
      sink_stall_pct <= (ph == 2) ? 50 : (ph == 3) ? 17 : 0;
      for (int w = 0; w < WORDS_PER_PHASE; w++) begin
        // back the block up while words keep coming
        if (ph == 0 && w == 20) hold_seq <= hold_seq + 1;
        send_random_word();
      end
    end
    s_axis_tvalid_i <= 1'b0;

    while (replies_pending.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
    if (n_mismatch == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule
